@@ rtl/core/sslp_pkg.sv @@
// Shared types, constants and helpers for the supply status line parser.
package sslp_pkg;

   localparam int LINE_DEPTH_DEFAULT = 40;

   localparam logic [7:0] LF_BYTE    = 8'h0A;
   localparam logic [7:0] CR_BYTE    = 8'h0D;
   localparam logic [7:0] DIGIT_BASE = 8'h30;
   localparam logic [7:0] TAG_V      = 8'h56;
   localparam logic [7:0] TAG_A      = 8'h41;
   localparam logic [7:0] TAG_U      = 8'h55;
   localparam logic [7:0] TAG_I      = 8'h49;
   localparam logic [7:0] TAG_P      = 8'h50;
   localparam logic [7:0] TAG_F      = 8'h46;

   localparam logic [15:0] INVALID_READING = 16'hFFFF;

   localparam logic FUNC_BYTE       = 1'b0;
   localparam logic FUNC_INVALIDATE = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] voltage_reading;
      logic [15:0] current_reading;
      logic [15:0] voltage_limit_reading;
      logic [15:0] current_limit_reading;
      logic [15:0] power_limit_reading;
      logic [15:0] status_reading;
      logic        line_done;
   } rsp_type;

   function automatic logic [15:0] weigh_digit(input logic [7:0] char_in,
                                               input logic [15:0] weight);
      logic [7:0]  digit;
      logic [15:0] wide;
      digit = char_in - DIGIT_BASE;
      wide  = {8'h00, digit};
      return wide * weight;
   endfunction

endpackage

@@ rtl/core/sslp_line_buffer.sv @@
// Line buffer with saturating write pointer and a write-through view.
module sslp_line_buffer #(
   parameter int LINE_DEPTH = sslp_pkg::LINE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            write_en,
   input  logic [7:0]                      write_byte,
   output logic [7:0]                      view_out [LINE_DEPTH],
   output logic [$clog2(LINE_DEPTH+1)-1:0] pointer_out
);
   import sslp_pkg::*;

   localparam int PTR_W = $clog2(LINE_DEPTH + 1);
   localparam int IDX_W = $clog2(LINE_DEPTH);

   logic [7:0]       buffer_ff [LINE_DEPTH];
   logic [PTR_W-1:0] pointer_ff;
   logic [PTR_W-1:0] pointer_in;
   logic             room;
   logic             store;
   logic [IDX_W-1:0] index;

   assign room  = pointer_ff < PTR_W'(LINE_DEPTH);
   assign store = write_en && room;
   assign index = pointer_ff[IDX_W-1:0];

   always_comb begin
      pointer_in = pointer_ff;
      if (write_en) begin
         if (write_byte == LF_BYTE) begin
            pointer_in = '0;
         end else if (room) begin
            pointer_in = pointer_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= '0;
         for (int i = 0; i < LINE_DEPTH; i++) begin
            buffer_ff[i] <= '0;
         end
      end else begin
         pointer_ff <= pointer_in;
         if (store) begin
            buffer_ff[index] <= write_byte;
         end
      end
   end

   for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_view
      assign view_out[g] = (store && index == IDX_W'(g)) ? write_byte : buffer_ff[g];
   end

   assign pointer_out = pointer_ff;

endmodule

@@ rtl/core/sslp_decoder.sv @@
// Fixed-offset field decode and reading update for one beat.
module sslp_decoder #(
   parameter int LINE_DEPTH = sslp_pkg::LINE_DEPTH_DEFAULT
) (
   input  sslp_pkg::req_type req_in,
   input  logic [7:0]        view_in [LINE_DEPTH],
   input  sslp_pkg::rsp_type prev_in,
   output sslp_pkg::rsp_type next_out
);
   import sslp_pkg::*;

   logic is_lf;
   logic framed;

   assign is_lf  = (req_in.rx_byte == LF_BYTE);
   assign framed = (view_in[37] == CR_BYTE) || (view_in[38] == CR_BYTE);

   always_comb begin
      next_out           = prev_in;
      next_out.line_done = 1'b0;
      if (req_in.func == FUNC_INVALIDATE) begin
         next_out.voltage_reading       = INVALID_READING;
         next_out.current_reading       = INVALID_READING;
         next_out.voltage_limit_reading = INVALID_READING;
         next_out.current_limit_reading = INVALID_READING;
         next_out.power_limit_reading   = INVALID_READING;
         next_out.status_reading        = INVALID_READING;
      end else if (is_lf) begin
         next_out.line_done = 1'b1;
         if (framed) begin
            if (view_in[0] == TAG_V) begin
               next_out.voltage_reading = weigh_digit(view_in[1], 16'd10000)
                  + weigh_digit(view_in[2], 16'd1000)
                  + weigh_digit(view_in[4], 16'd100)
                  + weigh_digit(view_in[5], 16'd10);
            end
            if (view_in[6] == TAG_A) begin
               next_out.current_reading = weigh_digit(view_in[7], 16'd1000)
                  + weigh_digit(view_in[9], 16'd100)
                  + weigh_digit(view_in[10], 16'd10)
                  + weigh_digit(view_in[11], 16'd1);
            end
            if (view_in[18] == TAG_U) begin
               next_out.voltage_limit_reading = weigh_digit(view_in[19], 16'd10)
                  + weigh_digit(view_in[20], 16'd1);
            end
            if (view_in[21] == TAG_I) begin
               next_out.current_limit_reading = weigh_digit(view_in[22], 16'd1000)
                  + weigh_digit(view_in[24], 16'd100)
                  + weigh_digit(view_in[25], 16'd10);
            end
            if (view_in[26] == TAG_P) begin
               next_out.power_limit_reading = weigh_digit(view_in[27], 16'd100)
                  + weigh_digit(view_in[28], 16'd10)
                  + weigh_digit(view_in[29], 16'd1);
            end
            if (view_in[30] == TAG_F) begin
               next_out.status_reading = weigh_digit(view_in[31], 16'd1);
            end
         end
      end
   end

endmodule

@@ rtl/core/supply_status_line_parser.sv @@
// Top level of the supply status line parser: input stage, decode, result stage.
//
//   channel | ports                        | direction | beat
//   req     | req_valid req_ready req_data | in        | one byte or invalidate
//   rsp     | rsp_valid rsp_ready rsp_data | out       | readings after that beat
//
// A beat accepted on req passes the input and result registers before rsp valid; one
// beat per cycle is sustained while rsp is not stalled, set by the single decode pass.
// Reset clears the line buffer, pointer and all readings to zero.
// A stalled rsp holds the result register; the input register still takes one
// beat, then req_ready drops until the result moves.
module supply_status_line_parser #(
   parameter int LINE_DEPTH = sslp_pkg::LINE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sslp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sslp_pkg::rsp_type rsp_data
);
   import sslp_pkg::*;

   localparam int PTR_W = $clog2(LINE_DEPTH + 1);

   logic             in_valid_ff;
   req_type          in_data_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;
   logic             advance;
   logic             write_en;
   logic [7:0]       view [LINE_DEPTH];
   logic [PTR_W-1:0] pointer;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign write_en  = advance && (in_data_ff.func == FUNC_BYTE);

   sslp_line_buffer #(.LINE_DEPTH(LINE_DEPTH)) u_line_buffer (
      .clock       (clock),
      .reset       (reset),
      .write_en    (write_en),
      .write_byte  (in_data_ff.rx_byte),
      .view_out    (view),
      .pointer_out (pointer)
   );

   sslp_decoder #(.LINE_DEPTH(LINE_DEPTH)) u_decoder (
      .req_in   (in_data_ff),
      .view_in  (view),
      .prev_in  (rsp_data_ff),
      .next_out (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_data_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pointer_bound: assert property (@(posedge clock) disable iff (reset)
      pointer <= PTR_W'(LINE_DEPTH))
      else $error("write pointer past line depth");

   a_lf_rewinds: assert property (@(posedge clock) disable iff (reset)
      (write_en && in_data_ff.rx_byte == LF_BYTE) |=> (pointer == '0 && rsp_data.line_done))
      else $error("line feed did not rewind pointer or flag line_done");

   a_invalidate: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.func == FUNC_INVALIDATE) |=>
         (rsp_data.voltage_reading == INVALID_READING
          && rsp_data.status_reading == INVALID_READING && !rsp_data.line_done))
      else $error("invalidate beat did not mark readings invalid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !advance)
      else $error("result overwritten while stalled");

endmodule

@@ tb/sv/supply_status_line_parser_tb.sv @@
// Self-checking testbench for the supply status line parser: status lines, noise and invalidates.
module supply_status_line_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sslp_pkg::*;

   localparam int DEPTH        = LINE_DEPTH_DEFAULT;
   localparam int ITEM_TARGET  = 1500;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   localparam int CR_NONE = 0;
   localparam int CR_37   = 1;
   localparam int CR_38   = 2;
   localparam int CR_BOTH = 3;

   localparam int FILL_DIGITS = 0;
   localparam int FILL_NINES  = 1;
   localparam int FILL_ZEROS  = 2;
   localparam int FILL_RANDOM = 3;

   localparam int STALL_NONE    = 0;
   localparam int STALL_RANDOM  = 1;
   localparam int STALL_PATTERN = 2;

   localparam logic [5:0] ALL_TAGS = 6'h3F;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   logic [7:0]  line_mem [0:63];
   int unsigned wr_ptr;
   rsp_type     readings;
   rsp_type     pending_readings [$];
   logic [7:0]  line_bytes [$];

   int beats_sent;
   int burst_left;
   bit idle_enable;
   int stall_mode;
   bit hold_request;
   int fail_count;
   int cycle_count;

   supply_status_line_parser #(
      .LINE_DEPTH(DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] line_char(int pos);
      if (pos >= DEPTH) return 8'h00;
      return line_mem[pos];
   endfunction

   function automatic logic [31:0] digit_of(int pos);
      logic [7:0] d;
      d = line_char(pos) - DIGIT_BASE;
      return {24'h000000, d};
   endfunction

   function automatic void advance_parser(req_type beat);
      logic        room;
      logic [31:0] acc;
      readings.line_done = 1'b0;
      if (beat.func == FUNC_INVALIDATE) begin
         readings.voltage_reading       = INVALID_READING;
         readings.current_reading       = INVALID_READING;
         readings.voltage_limit_reading = INVALID_READING;
         readings.current_limit_reading = INVALID_READING;
         readings.power_limit_reading   = INVALID_READING;
         readings.status_reading        = INVALID_READING;
      end else begin
         room = (wr_ptr < DEPTH);
         if (room) line_mem[wr_ptr] = beat.rx_byte;
         if (beat.rx_byte == LF_BYTE) begin
            wr_ptr = 0;
            readings.line_done = 1'b1;
            if (line_char(37) == CR_BYTE || line_char(38) == CR_BYTE) begin
               if (line_char(0) == TAG_V) begin
                  acc = digit_of(1) * 10000 + digit_of(2) * 1000 + digit_of(4) * 100
                        + digit_of(5) * 10;
                  readings.voltage_reading = acc[15:0];
               end
               if (line_char(6) == TAG_A) begin
                  acc = digit_of(7) * 1000 + digit_of(9) * 100 + digit_of(10) * 10
                        + digit_of(11);
                  readings.current_reading = acc[15:0];
               end
               if (line_char(18) == TAG_U) begin
                  acc = digit_of(19) * 10 + digit_of(20);
                  readings.voltage_limit_reading = acc[15:0];
               end
               if (line_char(21) == TAG_I) begin
                  acc = digit_of(22) * 1000 + digit_of(24) * 100 + digit_of(25) * 10;
                  readings.current_limit_reading = acc[15:0];
               end
               if (line_char(26) == TAG_P) begin
                  acc = digit_of(27) * 100 + digit_of(28) * 10 + digit_of(29);
                  readings.power_limit_reading = acc[15:0];
               end
               if (line_char(30) == TAG_F) begin
                  acc = digit_of(31);
                  readings.status_reading = acc[15:0];
               end
            end
         end else if (room) begin
            wr_ptr++;
         end
      end
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("%s: expected %0d (0x%h), got %0d (0x%h)", name, want, want, got, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("result beat with nothing expected: 0x%h", rsp_data);
            end else begin
               want = pending_readings.pop_front();
               check_field("voltage_reading", want.voltage_reading, rsp_data.voltage_reading);
               check_field("current_reading", want.current_reading, rsp_data.current_reading);
               check_field("voltage_limit_reading", want.voltage_limit_reading,
                           rsp_data.voltage_limit_reading);
               check_field("current_limit_reading", want.current_limit_reading,
                           rsp_data.current_limit_reading);
               check_field("power_limit_reading", want.power_limit_reading,
                           rsp_data.power_limit_reading);
               check_field("status_reading", want.status_reading, rsp_data.status_reading);
               check_field("line_done", {15'h0000, want.line_done},
                           {15'h0000, rsp_data.line_done});
            end
         end
         if (req_valid && req_ready) begin
            advance_parser(req_data);
            pending_readings.push_back(readings);
         end
      end
   end

   initial begin
      int phase;
      int hold_left;
      phase     = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               STALL_NONE:   rsp_ready <= 1'b1;
               STALL_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
               default:      rsp_ready <= ((phase % 7) != 3) && ((phase % 5) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("supply_status_line_parser: mismatch");
         $finish;
      end
   end

   task automatic send_beat(input logic func, input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         if (idle_enable) begin
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{func: func, rx_byte: value};
      do @(posedge clock); while (!req_ready);
      burst_left--;
      beats_sent++;
   endtask

   task automatic send_invalidate();
      send_beat(FUNC_INVALIDATE, 8'($urandom));
   endtask

   task automatic compose_line(input int cr_sites, input int fill, input logic [5:0] tags,
                               input int body_len);
      logic [7:0] c;
      line_bytes.delete();
      for (int i = 0; i < body_len; i++) begin
         case (fill)
            FILL_NINES:  c = DIGIT_BASE + 8'd9;
            FILL_ZEROS:  c = DIGIT_BASE;
            FILL_DIGITS: c = DIGIT_BASE + 8'($urandom_range(0, 9));
            default: begin
               c = 8'($urandom);
               if (c == LF_BYTE) c = 8'hF5;
            end
         endcase
         case (i)
            0:  if (tags[0]) c = TAG_V;
            6:  if (tags[1]) c = TAG_A;
            18: if (tags[2]) c = TAG_U;
            21: if (tags[3]) c = TAG_I;
            26: if (tags[4]) c = TAG_P;
            30: if (tags[5]) c = TAG_F;
            37: if (cr_sites[0]) c = CR_BYTE;
            38: if (cr_sites[1]) c = CR_BYTE;
            default: ;
         endcase
         line_bytes.push_back(c);
      end
      line_bytes.push_back(LF_BYTE);
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_beat(FUNC_BYTE, line_bytes[i]);
   endtask

   task automatic test_invalidate_and_bare_feed();
      send_beat(FUNC_BYTE, LF_BYTE);
      send_invalidate();
      send_beat(FUNC_BYTE, 8'h00);
      send_beat(FUNC_BYTE, 8'hFF);
      send_invalidate();
      send_beat(FUNC_BYTE, LF_BYTE);
   endtask

   task automatic test_framed_lines();
      compose_line(CR_37, FILL_NINES, ALL_TAGS, 38);
      send_line();
      compose_line(CR_38, FILL_ZEROS, ALL_TAGS, 39);
      send_line();
      compose_line(CR_BOTH, FILL_DIGITS, ALL_TAGS, 39);
      send_line();
   endtask

   task automatic test_unframed_and_missing_tags();
      compose_line(CR_NONE, FILL_DIGITS, ALL_TAGS, 39);
      send_line();
      compose_line(CR_37, FILL_DIGITS, 6'b101010, 38);
      send_line();
      compose_line(CR_38, FILL_DIGITS, 6'b010101, 39);
      send_line();
   endtask

   task automatic test_non_digit_bytes();
      compose_line(CR_37, FILL_RANDOM, ALL_TAGS, 38);
      send_line();
      compose_line(CR_38, FILL_RANDOM, ALL_TAGS, 39);
      send_line();
   endtask

   task automatic test_buffer_overflow();
      compose_line(CR_37, FILL_DIGITS, ALL_TAGS, DEPTH + 12);
      send_line();
      send_invalidate();
      compose_line(CR_BOTH, FILL_DIGITS, ALL_TAGS, 12);
      send_line();
   endtask

   task automatic test_backpressure();
      idle_enable  = 1'b0;
      stall_mode   = STALL_NONE;
      hold_request = 1'b1;
      repeat (3) begin
         compose_line(CR_37, FILL_DIGITS, ALL_TAGS, 38);
         send_line();
      end
   endtask

   task automatic test_random_traffic();
      int         pick;
      int         cr_sites;
      int         fill;
      logic [5:0] tags;
      while (beats_sent < ITEM_TARGET) begin
         stall_mode  = $urandom_range(STALL_NONE, STALL_PATTERN);
         idle_enable = ($urandom_range(0, 3) != 0);
         pick        = $urandom_range(0, 99);
         if (pick < 70) begin
            cr_sites = $urandom_range(CR_37, CR_BOTH);
            fill     = ($urandom_range(0, 5) == 0) ? FILL_RANDOM : FILL_DIGITS;
            tags     = ($urandom_range(0, 3) == 0) ? 6'($urandom) : ALL_TAGS;
            compose_line(cr_sites, fill, tags, (cr_sites == CR_37) ? 38 : 39);
            send_line();
         end else if (pick < 82) begin
            compose_line($urandom_range(CR_NONE, CR_BOTH), FILL_RANDOM, 6'($urandom),
                         $urandom_range(0, DEPTH + 10));
            send_line();
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 8)) send_beat(FUNC_BYTE, 8'($urandom));
         end else begin
            send_invalidate();
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      readings     = '0;
      wr_ptr       = 0;
      beats_sent   = 0;
      burst_left   = 0;
      idle_enable  = 1'b0;
      stall_mode   = STALL_NONE;
      hold_request = 1'b0;
      fail_count   = 0;
      cycle_count  = 0;
      for (int i = 0; i < 64; i++) line_mem[i] = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_invalidate_and_bare_feed();
      test_framed_lines();
      idle_enable = 1'b1;
      stall_mode  = STALL_RANDOM;
      test_unframed_and_missing_tags();
      test_non_digit_bytes();
      stall_mode = STALL_PATTERN;
      test_buffer_overflow();
      test_backpressure();
      test_random_traffic();

      @(negedge clock);
      req_valid  <= 1'b0;
      stall_mode = STALL_NONE;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_readings.size() == 0)
         $display("supply_status_line_parser: match");
      else
         $display("supply_status_line_parser: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/sslp_pkg.sv
rtl/core/sslp_line_buffer.sv
rtl/core/sslp_decoder.sv
rtl/core/supply_status_line_parser.sv
tb/sv/supply_status_line_parser_tb.sv
